// File: rtl/setl_pkg.sv
package setl_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W + 1 > 8) ? CNT_W + 1 : 8;
  localparam logic [5:0] REF_MAX = 6'd63;

  typedef struct packed {
    logic [31:0] t;
    logic [15:0] name;
    logic [15:0] tgt;
    logic        rel;
    logic [5:0]  refs;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_ADDABS = 3'd1,
    OP_ADDREL = 3'd2,
    OP_REMOVE = 3'd3,
    OP_READ   = 3'd4,
    OP_FIND   = 3'd5,
    OP_RSV6   = 3'd6,
    OP_RSV7   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_SAME     = 3'd1,
    STS_NOTARGET = 3'd2,
    STS_TGTREL   = 3'd3,
    STS_OFFSET   = 3'd4,
    STS_POS      = 3'd5,
    STS_NOTFOUND = 3'd6,
    STS_FULL     = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    PH_REFS,
    PH_OWN,
    PH_FINAL
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_INS_START,
    S_INS_RD,
    S_INS_EV,
    S_INS_WR,
    S_SC_RD,
    S_SC_EV,
    S_SC_DONE,
    S_AR_RD,
    S_AR_EV,
    S_RM_RD,
    S_RM_EV,
    S_RM_OWN,
    S_ER_RD,
    S_ER_EV,
    S_ER_DONE,
    S_RD_A,
    S_RD_B,
    S_RD_C,
    S_DONE
  } state_t;

endpackage

// File: rtl/setl_ram.sv
module setl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sorted_event_timeline_table_core.sv
// Sorted event timeline table.
// Input channel s_*: one command per transfer. s_tuser carries the opcode
// (clear, add absolute, add relative, remove, read, find); s_tdata carries
// time value, event name, target name and position.
// Output channel m_*: exactly one result per command, in command order.
// cfg_wr_en/cfg_wr_data set the name given to the end marker on clear.
// One command is processed at a time; s_tready is high only while idle.
// Each table step goes through the table memory (one write port, one read
// port) with a registered read: clear and add-absolute shift entries up
// to insert, find scans, add-relative scans and then inserts, and remove
// erases each entry that refers to it, updates its target, then erases it.
// The result sits in an output register; the next command is accepted
// while it waits. If a new result is ready before the old one is taken,
// the sequencer holds until m_tready frees the register.
// Reset (rst, synchronous) empties the table and clears the end name.
// No clearing pass: table words are only read below the entry count.
module sorted_event_timeline_table_core
  import setl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [2:0]   s_tuser,   // op
  input  logic [71:0]  s_tdata,   // time_value, event_name, target_name, position
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // status, result_position, entry_time, delta_time,
                                  // read_name, read_target, is_relative, ref_count
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);

  state_t st, st_next;
  phase_t phase, phase_next;
  op_t op_r;
  status_t status, status_next;
  logic [CNT_W-1:0] cnt, cnt_next, i, i_next, j, j_next;
  logic [IDX_W-1:0] idx, idx_next, rpos, rpos_next;
  logic [5:0] left, left_next;
  logic [15:0] end_name, owner, owner_next, key, key_next;
  logic key_rel, key_rel_next, rel_r, rel_r_next, found, found_next;
  logic [31:0] tv_r;
  logic [15:0] ev_r, tg_r;
  logic [6:0] pos_r;
  entry_t hit, hit_next, ins, ins_next, ent, ent_next;
  logic [32:0] delta, delta_next;
  logic rd_ok, rd_ok_next;

  logic we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t wdata, rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  logic out_valid;
  logic [119:0] out_data;

  logic signed [CMP_W-1:0] p_s, n_s;
  logic signed [32:0] sum_s, last_s;
  logic match;

  assign rdata = entry_t'(rdata_raw);

  setl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign s_tready = (st == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  assign match  = key_rel ? (rdata.rel && rdata.tgt == key) : (rdata.name == key);
  assign sum_s  = $signed({hit.t[31], hit.t}) + $signed({tv_r[31], tv_r});
  assign last_s = $signed({rdata.t[31], rdata.t});

  always_comb begin
    p_s = $signed({{(CMP_W - 7){pos_r[6]}}, pos_r});
    n_s = $signed(CMP_W'(cnt));
    if (op_r == OP_REMOVE) begin
      n_s = n_s - CMP_W'(1);
    end
  end

  always_comb begin
    logic signed [CMP_W-1:0] pi;
    pi = p_s + n_s;
    st_next = st;
    phase_next = phase;
    status_next = status;
    cnt_next = cnt;
    i_next = i;
    j_next = j;
    idx_next = idx;
    rpos_next = rpos;
    left_next = left;
    owner_next = owner;
    key_next = key;
    key_rel_next = key_rel;
    rel_r_next = rel_r;
    found_next = found;
    hit_next = hit;
    ins_next = ins;
    ent_next = ent;
    delta_next = delta;
    rd_ok_next = rd_ok;
    we = 1'b0;
    waddr = i[IDX_W-1:0];
    wdata = rdata;
    raddr = i[IDX_W-1:0];

    unique case (st)
      S_IDLE: begin
        if (s_tvalid) begin
          st_next = S_DISP;
          status_next = STS_OK;
          rpos_next = '0;
          rd_ok_next = 1'b0;
        end
      end
      S_DISP: begin
        unique case (op_r)
          OP_CLEAR: begin
            cnt_next = '0;
            ins_next = '{t: tv_r, name: end_name, tgt: 16'd0, rel: 1'b0, refs: 6'd0};
            st_next = S_INS_START;
          end
          OP_ADDABS: begin
            if (cnt >= CNT_W'(TABLE_DEPTH)) begin
              status_next = STS_FULL;
              st_next = S_DONE;
            end else begin
              ins_next = '{t: tv_r, name: ev_r, tgt: 16'd0, rel: 1'b0, refs: 6'd0};
              st_next = S_INS_START;
            end
          end
          OP_ADDREL: begin
            if (cnt >= CNT_W'(TABLE_DEPTH)) begin
              status_next = STS_FULL;
              st_next = S_DONE;
            end else if (ev_r == tg_r) begin
              status_next = STS_SAME;
              st_next = S_DONE;
            end else begin
              key_next = tg_r;
              key_rel_next = 1'b0;
              i_next = '0;
              st_next = S_SC_RD;
            end
          end
          OP_REMOVE, OP_READ: begin
            if (n_s < $signed(CMP_W'(1)) || p_s < -n_s || p_s >= n_s) begin
              status_next = STS_POS;
              st_next = S_DONE;
            end else begin
              idx_next = p_s[CMP_W-1] ? pi[IDX_W-1:0] : p_s[IDX_W-1:0];
              rpos_next = p_s[CMP_W-1] ? pi[IDX_W-1:0] : p_s[IDX_W-1:0];
              st_next = (op_r == OP_REMOVE) ? S_RM_RD : S_RD_A;
            end
          end
          OP_FIND: begin
            key_next = ev_r;
            key_rel_next = 1'b0;
            i_next = '0;
            st_next = S_SC_RD;
          end
          default: st_next = S_DONE;
        endcase
      end
      S_INS_START: begin
        i_next = cnt;
        st_next = (cnt == '0) ? S_INS_WR : S_INS_RD;
      end
      S_INS_RD: begin
        raddr = IDX_W'(i - CNT_W'(1));
        st_next = S_INS_EV;
      end
      S_INS_EV: begin
        if ($signed(rdata.t) >= $signed(ins.t)) begin
          we = 1'b1;
          wdata = rdata;
          i_next = i - CNT_W'(1);
          st_next = (i == CNT_W'(1)) ? S_INS_WR : S_INS_RD;
        end else begin
          st_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        we = 1'b1;
        wdata = ins;
        cnt_next = cnt + CNT_W'(1);
        rpos_next = i[IDX_W-1:0];
        st_next = S_DONE;
      end
      S_SC_RD: begin
        if (i == cnt) begin
          found_next = 1'b0;
          st_next = S_SC_DONE;
        end else begin
          st_next = S_SC_EV;
        end
      end
      S_SC_EV: begin
        if (match) begin
          found_next = 1'b1;
          j_next = i;
          hit_next = rdata;
          st_next = S_SC_DONE;
        end else begin
          i_next = i + CNT_W'(1);
          st_next = S_SC_RD;
        end
      end
      S_SC_DONE: begin
        unique case (op_r)
          OP_FIND: begin
            if (found) begin
              rpos_next = j[IDX_W-1:0];
            end else begin
              status_next = STS_NOTFOUND;
            end
            st_next = S_DONE;
          end
          OP_ADDREL: begin
            if (!found) begin
              status_next = STS_NOTARGET;
              st_next = S_DONE;
            end else if (hit.rel) begin
              status_next = STS_TGTREL;
              st_next = S_DONE;
            end else begin
              st_next = S_AR_RD;
            end
          end
          OP_REMOVE: begin
            if (phase == PH_REFS) begin
              if (found) begin
                i_next = j;
                st_next = S_ER_RD;
              end else begin
                st_next = S_RM_OWN;
              end
            end else begin
              if (found && hit.refs != 6'd0) begin
                we = 1'b1;
                waddr = j[IDX_W-1:0];
                wdata = hit;
                wdata.refs = hit.refs - 6'd1;
              end
              i_next = CNT_W'(idx);
              phase_next = PH_FINAL;
              st_next = S_ER_RD;
            end
          end
          default: st_next = S_DONE;
        endcase
      end
      S_AR_RD: begin
        raddr = IDX_W'(cnt - CNT_W'(1));
        st_next = S_AR_EV;
      end
      S_AR_EV: begin
        if (sum_s < 0 || sum_s >= last_s) begin
          status_next = STS_OFFSET;
          st_next = S_DONE;
        end else begin
          we = 1'b1;
          waddr = j[IDX_W-1:0];
          wdata = hit;
          wdata.refs = (hit.refs == REF_MAX) ? REF_MAX : hit.refs + 6'd1;
          ins_next = '{t: sum_s[31:0], name: ev_r, tgt: tg_r, rel: 1'b1, refs: 6'd0};
          st_next = S_INS_START;
        end
      end
      S_RM_RD: begin
        raddr = idx;
        st_next = S_RM_EV;
      end
      S_RM_EV: begin
        owner_next = rdata.tgt;
        rel_r_next = rdata.rel;
        left_next = rdata.refs;
        if (rdata.refs != 6'd0) begin
          key_next = rdata.name;
          key_rel_next = 1'b1;
          phase_next = PH_REFS;
          i_next = '0;
          st_next = S_SC_RD;
        end else begin
          st_next = S_RM_OWN;
        end
      end
      S_RM_OWN: begin
        if (rel_r) begin
          key_next = owner;
          key_rel_next = 1'b0;
          phase_next = PH_OWN;
          i_next = '0;
          st_next = S_SC_RD;
        end else begin
          i_next = CNT_W'(idx);
          phase_next = PH_FINAL;
          st_next = S_ER_RD;
        end
      end
      S_ER_RD: begin
        raddr = IDX_W'(i + CNT_W'(1));
        if (i + CNT_W'(1) >= cnt) begin
          cnt_next = cnt - CNT_W'(1);
          st_next = S_ER_DONE;
        end else begin
          st_next = S_ER_EV;
        end
      end
      S_ER_EV: begin
        we = 1'b1;
        wdata = rdata;
        i_next = i + CNT_W'(1);
        st_next = S_ER_RD;
      end
      S_ER_DONE: begin
        if (phase == PH_REFS) begin
          if (j < CNT_W'(idx)) begin
            idx_next = idx - IDX_W'(1);
          end
          left_next = left - 6'd1;
          if (left != 6'd1) begin
            i_next = '0;
            st_next = S_SC_RD;
          end else begin
            st_next = S_RM_OWN;
          end
        end else begin
          st_next = S_DONE;
        end
      end
      S_RD_A: begin
        raddr = idx;
        st_next = S_RD_B;
      end
      S_RD_B: begin
        ent_next = rdata;
        rd_ok_next = 1'b1;
        raddr = idx - IDX_W'(1);
        if (idx == '0) begin
          delta_next = {rdata.t[31], rdata.t};
          st_next = S_DONE;
        end else begin
          st_next = S_RD_C;
        end
      end
      S_RD_C: begin
        delta_next = {ent.t[31], ent.t} - {rdata.t[31], rdata.t};
        st_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          st_next = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      cnt <= '0;
      end_name <= '0;
      out_valid <= 1'b0;
      phase <= PH_REFS;
    end else begin
      st <= st_next;
      cnt <= cnt_next;
      phase <= phase_next;
      if (cfg_wr_en) begin
        end_name <= cfg_wr_data;
      end
      if (st == S_DONE && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_IDLE && s_tvalid) begin
      op_r <= op_t'(s_tuser);
      tv_r <= s_tdata[31:0];
      ev_r <= s_tdata[47:32];
      tg_r <= s_tdata[63:48];
      pos_r <= s_tdata[70:64];
    end
    status <= status_next;
    i <= i_next;
    j <= j_next;
    idx <= idx_next;
    rpos <= rpos_next;
    left <= left_next;
    owner <= owner_next;
    key <= key_next;
    key_rel <= key_rel_next;
    rel_r <= rel_r_next;
    found <= found_next;
    hit <= hit_next;
    ins <= ins_next;
    ent <= ent_next;
    delta <= delta_next;
    rd_ok <= rd_ok_next;
    if (st == S_DONE && (!out_valid || m_tready)) begin
      if (rd_ok && status == STS_OK) begin
        out_data <= {7'd0, ent.refs, ent.rel, (ent.rel ? ent.tgt : 16'd0), ent.name,
                     delta, ent.t, 6'(rpos), status};
      end else begin
        out_data <= {111'd0, (status == STS_OK) ? 6'(rpos) : 6'd0, status};
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> !s_tready)
    else $error("command accepted while busy");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:0] != STS_OK) |-> (m_tdata[8:3] == 6'd0))
    else $error("error result carries a position");

endmodule
